/* hw/rtl/pan_tilt_scan_frame_controller_core_defines.svh */
// Assertion macros for the pan/tilt scan frame controller.
`ifndef PAN_TILT_SCAN_FRAME_CONTROLLER_CORE_DEFINES_SVH
`define PAN_TILT_SCAN_FRAME_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication, reset-qualified
`define PTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset-qualified
`define PTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/pts_pkg.sv */
// Shared types and constants for the pan/tilt scan frame controller.
package pts_pkg;

    localparam int FRAME_BYTES     = 13;
    localparam int IDX_W           = $clog2(FRAME_BYTES);
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] SYNC_BYTE  = 8'hFF;
    localparam logic [7:0] FRAME_HEAD = 8'hF6;
    localparam logic [7:0] AXIS_PAN   = 8'h01;
    localparam logic [7:0] AXIS_TILT  = 8'h02;
    localparam logic [6:0] LOW7_MASK  = 7'h7F;

    localparam logic [7:0] RST_PAN_START  = 8'd153;
    localparam logic [7:0] RST_PAN_END    = 8'd110;
    localparam logic [7:0] RST_TILT_START = 8'd131;
    localparam logic [7:0] RST_TILT_END   = 8'd141;

    localparam logic [IDX_W-1:0] IDX_PAN_POS  = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_TILT_POS = IDX_W'(5);
    localparam logic [IDX_W-1:0] IDX_FRAME_END = IDX_W'(FRAME_BYTES - 1);

    typedef enum logic [1:0] {
        OP_STEP   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_SEND   = 2'd2,
        OP_HOME   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_PAN_START  = 2'd0,
        REG_PAN_END    = 2'd1,
        REG_TILT_START = 2'd2,
        REG_TILT_END   = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        JOB_SERVO_PAN,
        JOB_SERVO_BOTH,
        JOB_FRAME
    } job_kind_t;

    typedef struct packed {
        logic [7:0] pan_start;
        logic [7:0] pan_end;
        logic [7:0] tilt_start;
        logic [7:0] tilt_end;
    } cfg_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [7:0]  pan;
        logic [7:0]  tilt;
        logic [15:0] sum;
        logic [15:0] range;
    } job_t;

    typedef struct packed {
        logic push;
        job_t job;
    } q_push_t;

    typedef struct packed {
        logic valid;
        logic full;
        job_t job;
    } q_head_t;

endpackage

/* hw/rtl/pts_regs.sv */
// APB configuration registers for the scan limits.
module pts_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output pts_pkg::cfg_t     cfg
);
    import pts_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t sel;
    logic     wr;

    assign pready = 1'b1;
    assign sel    = reg_idx_t'(paddr[3:2]);
    assign wr     = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pan_start  <= RST_PAN_START;
            cfg_reg.pan_end    <= RST_PAN_END;
            cfg_reg.tilt_start <= RST_TILT_START;
            cfg_reg.tilt_end   <= RST_TILT_END;
        end
        else if (wr)
        begin
            case (sel)
                REG_PAN_START:  cfg_reg.pan_start  <= pwdata[7:0];
                REG_PAN_END:    cfg_reg.pan_end    <= pwdata[7:0];
                REG_TILT_START: cfg_reg.tilt_start <= pwdata[7:0];
                REG_TILT_END:   cfg_reg.tilt_end   <= pwdata[7:0];
                default:        cfg_reg.tilt_end   <= cfg_reg.tilt_end;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_PAN_START:  prdata = {24'd0, cfg_reg.pan_start};
            REG_PAN_END:    prdata = {24'd0, cfg_reg.pan_end};
            REG_TILT_START: prdata = {24'd0, cfg_reg.tilt_start};
            REG_TILT_END:   prdata = {24'd0, cfg_reg.tilt_end};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

/* hw/rtl/pts_front.sv */
// Front end: accepts items, updates scan state, queues output jobs.
module pts_front (
    input  logic              clk,
    input  logic              rst_n,
    input  pts_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        op,
    input  logic [15:0]       adc_sample,
    input  logic [15:0]       range_count,
    input  logic              echo_finished,
    input  logic              q_full,
    output pts_pkg::q_push_t  q_push
);
    import pts_pkg::*;

    logic [7:0]  pan_reg, pan_next;
    logic [7:0]  tilt_reg, tilt_next;
    logic        up_reg, up_next;
    logic        stopping_reg, stopping_next;
    logic        stopped_reg, stopped_next;
    logic [15:0] sum_reg, sum_next;

    op_t  op_c;
    logic accept;
    logic turned;
    logic [7:0] pan_mv;
    logic [7:0] tilt_mv;
    job_t job;
    logic gen;

    assign op_c     = op_t'(op);
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        pan_next      = pan_reg;
        tilt_next     = tilt_reg;
        up_next       = up_reg;
        stopping_next = stopping_reg;
        stopped_next  = stopped_reg;
        sum_next      = sum_reg;
        turned        = 1'b0;
        pan_mv        = pan_reg;
        tilt_mv       = tilt_reg;
        gen           = 1'b0;
        job.kind      = JOB_SERVO_PAN;
        job.pan       = pan_reg;
        job.tilt      = tilt_reg;
        job.sum       = sum_reg;
        job.range     = echo_finished ? range_count : 16'd0;

        if (op_c == OP_HOME)
        begin
            pan_next      = cfg.pan_start;
            tilt_next     = cfg.tilt_start;
            up_next       = 1'b0;
            stopping_next = 1'b0;
            stopped_next  = 1'b0;
            gen           = 1'b1;
            job.kind      = JOB_SERVO_BOTH;
            job.pan       = cfg.pan_start;
            job.tilt      = cfg.tilt_start;
        end
        else if (!stopped_reg)
        begin
            case (op_c)
                OP_STEP:
                begin
                    if (!up_reg)
                    begin
                        if (pan_reg > cfg.pan_end)
                            pan_mv = pan_reg - 8'd1;
                        if (pan_mv <= cfg.pan_end)
                        begin
                            pan_mv  = cfg.pan_end;
                            up_next = 1'b1;
                            turned  = 1'b1;
                        end
                    end
                    else
                    begin
                        if (pan_reg < cfg.pan_start)
                            pan_mv = pan_reg + 8'd1;
                        if (pan_mv >= cfg.pan_start)
                        begin
                            pan_mv  = cfg.pan_start;
                            up_next = 1'b0;
                            turned  = 1'b1;
                        end
                    end
                    if (stopping_reg)
                        stopped_next = 1'b1;
                    if (turned)
                    begin
                        if (tilt_reg < cfg.tilt_end)
                            tilt_mv = tilt_reg + 8'd1;
                        if (tilt_mv >= cfg.tilt_end)
                        begin
                            tilt_mv       = cfg.tilt_end;
                            stopping_next = 1'b1;
                        end
                    end
                    pan_next  = pan_mv;
                    tilt_next = tilt_mv;
                    gen       = 1'b1;
                    job.kind  = turned ? JOB_SERVO_BOTH : JOB_SERVO_PAN;
                    job.pan   = pan_mv;
                    job.tilt  = tilt_mv;
                end
                OP_SAMPLE:
                    sum_next = sum_reg + {4'd0, adc_sample[15:4]};
                OP_SEND:
                begin
                    sum_next = 16'd0;
                    gen      = 1'b1;
                    job.kind = JOB_FRAME;
                end
                default:
                    gen = 1'b0;
            endcase
        end
    end

    assign q_push.push = accept && gen;
    assign q_push.job  = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pan_reg      <= RST_PAN_START;
            tilt_reg     <= RST_TILT_START;
            up_reg       <= 1'b0;
            stopping_reg <= 1'b0;
            stopped_reg  <= 1'b0;
            sum_reg      <= 16'd0;
        end
        else if (accept)
        begin
            pan_reg      <= pan_next;
            tilt_reg     <= tilt_next;
            up_reg       <= up_next;
            stopping_reg <= stopping_next;
            stopped_reg  <= stopped_next;
            sum_reg      <= sum_next;
        end
    end

endmodule

/* hw/rtl/pts_queue.sv */
// Job queue between front and back ends.
module pts_queue #(
    parameter int DEPTH = pts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pts_pkg::q_push_t  q_push,
    input  logic              pop,
    output pts_pkg::q_head_t  q_head
);
    import pts_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign q_head.valid = (count_reg != '0);
    assign q_head.full  = (count_reg == CNT_W'(DEPTH));
    assign q_head.job   = mem[rd_ptr_reg];

    assign do_push = q_push.push && !q_head.full;
    assign do_pop  = pop && q_head.valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= q_push.job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

/* hw/rtl/pts_back.sv */
// Back end: serializes queued jobs into servo packets and host frames.
module pts_back (
    input  logic              clk,
    input  logic              rst_n,
    input  pts_pkg::q_head_t  q_head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              link,
    output logic [7:0]        data_byte,
    output logic              packet_end,
    output logic              last
);
    import pts_pkg::*;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic             link_reg, pend_reg, last_reg;
    logic [7:0]       byte_reg;

    logic             load;
    logic [IDX_W-1:0] end_idx;
    logic [7:0]       byte_c;
    logic             link_c, pend_c, last_c;
    job_t             j;

    assign j    = q_head.job;
    assign load = !valid_reg || !out_stall;

    always_comb
    begin
        case (j.kind)
            JOB_SERVO_PAN:  end_idx = IDX_PAN_POS;
            JOB_SERVO_BOTH: end_idx = IDX_TILT_POS;
            JOB_FRAME:      end_idx = IDX_FRAME_END;
            default:        end_idx = IDX_PAN_POS;
        endcase
    end

    always_comb
    begin
        link_c = (j.kind == JOB_FRAME);
        last_c = (idx_reg == end_idx);
        if (j.kind == JOB_FRAME)
        begin
            pend_c = (idx_reg == IDX_FRAME_END);
            case (idx_reg)
                4'd0:    byte_c = FRAME_HEAD;
                4'd1:    byte_c = {7'd0, j.sum[15]};
                4'd2:    byte_c = {1'b0, j.sum[14:8] & LOW7_MASK};
                4'd3:    byte_c = {7'd0, j.sum[7]};
                4'd4:    byte_c = {1'b0, j.sum[6:0] & LOW7_MASK};
                4'd5:    byte_c = {7'd0, j.range[15]};
                4'd6:    byte_c = {1'b0, j.range[14:8] & LOW7_MASK};
                4'd7:    byte_c = {7'd0, j.range[7]};
                4'd8:    byte_c = {1'b0, j.range[6:0] & LOW7_MASK};
                4'd9:    byte_c = {7'd0, j.pan[7]};
                4'd10:   byte_c = {1'b0, j.pan[6:0] & LOW7_MASK};
                4'd11:   byte_c = {7'd0, j.tilt[7]};
                4'd12:   byte_c = {1'b0, j.tilt[6:0] & LOW7_MASK};
                default: byte_c = 8'd0;
            endcase
        end
        else
        begin
            pend_c = (idx_reg == IDX_PAN_POS) || (idx_reg == IDX_TILT_POS);
            case (idx_reg)
                4'd0:    byte_c = SYNC_BYTE;
                4'd1:    byte_c = AXIS_PAN;
                4'd2:    byte_c = j.pan;
                4'd3:    byte_c = SYNC_BYTE;
                4'd4:    byte_c = AXIS_TILT;
                4'd5:    byte_c = j.tilt;
                default: byte_c = 8'd0;
            endcase
        end
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next = q_head.valid;
            if (q_head.valid)
            begin
                if (last_c)
                begin
                    idx_next = '0;
                    pop      = 1'b1;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && q_head.valid)
        begin
            link_reg <= link_c;
            byte_reg <= byte_c;
            pend_reg <= pend_c;
            last_reg <= last_c;
        end
    end

    assign out_valid  = valid_reg;
    assign link       = link_reg;
    assign data_byte  = byte_reg;
    assign packet_end = pend_reg;
    assign last       = last_reg;

endmodule

/* hw/rtl/pan_tilt_scan_frame_controller_core.sv */
// Top level of the pan/tilt raster scan sequencer with servo and host byte output.
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------------------
//  in      | in_valid / in_stall | op, adc_sample, range_count, echo_finished
//  out     | out_valid/out_stall | link, data_byte, packet_end, last
//  cfg     | APB psel/penable    | paddr[3:2] selects one of four 8-bit limits
//
// The front end takes one item per cycle while the job queue has room; sample
// items, and items other than home to a stopped scan, leave no job. The back end
// emits one byte per cycle while out_stall is low: 3 for a plain step, 6 for a
// turning step or home, 13 for a frame, so sustained rate is set by the serializer.
// out_stall holds the output register and backs up into the queue, then in_stall.
// Reset restores limits and scan state at once; no clearing pass.
module pan_tilt_scan_frame_controller_core #(
    parameter int QUEUE_DEPTH = pts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [15:0] adc_sample,
    input  logic [15:0] range_count,
    input  logic        echo_finished,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        link,
    output logic [7:0]  data_byte,
    output logic        packet_end,
    output logic        last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pts_pkg::*;

    cfg_t    cfg;
    q_push_t q_push;
    q_head_t q_head;
    logic    pop;

    pts_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pts_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .adc_sample    (adc_sample),
        .range_count   (range_count),
        .echo_finished (echo_finished),
        .q_full        (q_head.full),
        .q_push        (q_push)
    );

    pts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .pop    (pop),
        .q_head (q_head)
    );

    pts_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_head     (q_head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .link       (link),
        .data_byte  (data_byte),
        .packet_end (packet_end),
        .last       (last)
    );

`include "pan_tilt_scan_frame_controller_core_defines.svh"

    `PTS_ASSERT_NOW(a_last_ends_packet, out_valid && last, packet_end, "last without packet_end")
    `PTS_ASSERT_NOW(a_frame_end_is_last, out_valid && link && packet_end, last, "frame end not last")
    `PTS_ASSERT_NEXT(a_home_queues_job, in_valid && !in_stall && (op == OP_HOME), q_head.valid || out_valid, "home item left no output work")

endmodule
